// File: hw/rtl/ffba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

  // pool size default
  localparam int POOL_BYTES_DEF = 1024;

  // allocation map word: one bit per byte
  localparam int WORD_W      = 16;
  localparam int WORD_BITS_W = $clog2(WORD_W);

  // request byte count width
  localparam int CNT_W = 11;

  // request kinds
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  // request payload
  typedef struct packed {
    logic             func;
    logic [CNT_W-1:0] byte_count;
    logic [31:0]      free_address;
  } req_t;

  // result payload
  typedef struct packed {
    logic [31:0] result_address;
    logic [1:0]  status;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic check;
    logic scan_init;
    logic scan_step;
    logic load_range;
    logic mark_step;
    logic clear_step;
    logic res_err;
    logic res_nofit;
    logic res_ok;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic err;
    logic alloc;
    logic hit;
    logic scan_end;
    logic mark_last;
    logic clear_last;
  } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/ffba_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ffba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ffba_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ffba_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  output logic               out_valid,
  output ffba_pkg::cmd_t     cmd,
  input  wire ffba_pkg::sts_t sts
);

  import ffba_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_EVAL  = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_MARK  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        priority if (sts.err) begin
          cmd.res_err = 1'b1;
          state_nxt   = S_DONE;
        end else if (sts.alloc) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end else begin
          cmd.load_range = 1'b1;
          state_nxt      = S_MARK;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        priority if (sts.hit) begin
          cmd.load_range = 1'b1;
          state_nxt      = S_MARK;
        end else if (sts.scan_end) begin
          cmd.res_nofit = 1'b1;
          state_nxt     = S_DONE;
        end
      end
      S_MARK: begin
        cmd.mark_step = 1'b1;
        if (sts.mark_last) begin
          cmd.res_ok = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // state register, clearing pass first after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

`default_nettype wire

// File: hw/rtl/ffba_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ffba_dp #(
  parameter int POOL_BYTES = ffba_pkg::POOL_BYTES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic [31:0]    cfg_wdata,
  input  wire ffba_pkg::req_t in_req,
  input  wire ffba_pkg::cmd_t cmd,
  output ffba_pkg::sts_t      sts,
  output ffba_pkg::rsp_t      out_rsp
);

  import ffba_pkg::*;

  localparam int W     = WORD_W;
  localparam int WB    = WORD_BITS_W;
  localparam int DEPTH = (POOL_BYTES + W - 1) / W;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OFF_W = AW + WB;
  localparam int SUM_W = ((OFF_W > CNT_W) ? OFF_W : CNT_W) + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  // bytes of the last word that lie past the pool read as taken
  function automatic logic [W-1:0] pad_mask_f();
    logic [W-1:0] m;
    m = '0;
    for (int i = 0; i < W; i++) begin
      m[i] = (((DEPTH - 1) * W + i) >= POOL_BYTES);
    end
    return m;
  endfunction

  localparam logic [W-1:0] PAD_MASK = pad_mask_f();

  // registers
  req_t             req_r,      req_nxt;
  logic [31:0]      base_r,     base_nxt;
  logic [32:0]      diff_r,     diff_nxt;
  logic [AW-1:0]    rd_idx_r,   rd_idx_nxt;
  logic [AW-1:0]    eval_idx_r, eval_idx_nxt;
  logic             eval_v_r,   eval_v_nxt;
  logic [CNT_W-1:0] run_r,      run_nxt;
  logic [OFF_W-1:0] lo_r,       lo_nxt;
  logic [OFF_W-1:0] hi_r,       hi_nxt;
  logic [AW-1:0]    mrd_idx_r,  mrd_idx_nxt;
  logic [AW-1:0]    wr_idx_r,   wr_idx_nxt;
  logic             pend_r,     pend_nxt;
  logic [AW-1:0]    clr_idx_r,  clr_idx_nxt;
  rsp_t             res_r,      res_nxt;

  // map memory ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [W-1:0]  ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [W-1:0]  ram_rdata;

  // scan word evaluation
  logic [W-1:0]     word_eff;
  logic [WB:0]      lastp1 [W];
  logic [CNT_W:0]   total  [W];
  logic [W-1:0]     hit_vec;
  logic [WB-1:0]    hit_pos;
  logic             any_hit;
  logic [OFF_W-1:0] end_off;
  logic [OFF_W-1:0] lo_alloc;
  logic [OFF_W-1:0] lo_free;
  logic [OFF_W-1:0] hi_free;

  // request checks
  logic        is_alloc;
  logic        zero_cnt;
  logic        too_big;
  logic [32:0] free_end;
  logic        free_bad;

  // mark masks
  logic [AW-1:0] lo_word;
  logic [AW-1:0] hi_word;
  logic [W-1:0]  lo_mask;
  logic [W-1:0]  hi_mask;
  logic [W-1:0]  mark_mask;
  logic [W-1:0]  mark_wdata;

  ffba_ram #(
    .WIDTH (W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // request checks
  always_comb begin
    is_alloc = (req_r.func == FUNC_ALLOC);
    zero_cnt = (req_r.byte_count == '0);
    too_big  = (32'(req_r.byte_count) > 32'(POOL_BYTES));
    free_end = {1'b0, diff_r[31:0]} + 33'(req_r.byte_count);
    free_bad = diff_r[32] || (free_end > 33'(POOL_BYTES));
  end

  // per-position free run ending at each bit of the scanned word
  always_comb begin
    word_eff = ram_rdata | ((eval_idx_r == LAST_IDX) ? PAD_MASK : '0);
    for (int b = 0; b < W; b++) begin
      lastp1[b] = '0;
      for (int j = 0; j < W; j++) begin
        if (j <= b && word_eff[j]) begin
          lastp1[b] = (WB+1)'(j + 1);
        end
      end
      total[b] = ((lastp1[b] == '0) ? {1'b0, run_r} : '0)
               + (CNT_W+1)'(b + 1) - (CNT_W+1)'(lastp1[b]);
      hit_vec[b] = (total[b] >= {1'b0, req_r.byte_count});
    end
    // lowest position where the run is long enough
    hit_pos = '0;
    for (int b = W - 1; b >= 0; b--) begin
      if (hit_vec[b]) begin
        hit_pos = WB'(b);
      end
    end
    any_hit  = eval_v_r && (hit_vec != '0);
    end_off  = {eval_idx_r, hit_pos};
    lo_alloc = OFF_W'(SUM_W'(end_off) + SUM_W'(1) - SUM_W'(req_r.byte_count));
    lo_free  = diff_r[OFF_W-1:0];
    hi_free  = OFF_W'(SUM_W'(lo_free) + SUM_W'(req_r.byte_count) - SUM_W'(1));
  end

  // read-modify-write mask for the word under update
  always_comb begin
    lo_word    = lo_r[OFF_W-1:WB];
    hi_word    = hi_r[OFF_W-1:WB];
    lo_mask    = (wr_idx_r == lo_word) ? ({W{1'b1}} << lo_r[WB-1:0]) : {W{1'b1}};
    hi_mask    = (wr_idx_r == hi_word) ? ({W{1'b1}} >> (~hi_r[WB-1:0])) : {W{1'b1}};
    mark_mask  = lo_mask & hi_mask;
    mark_wdata = is_alloc ? (ram_rdata | mark_mask) : (ram_rdata & ~mark_mask);
  end

  // memory port selection
  always_comb begin
    ram_re    = cmd.scan_step || cmd.mark_step;
    ram_raddr = cmd.mark_step ? mrd_idx_r : rd_idx_r;
    ram_we    = cmd.clear_step || (cmd.mark_step && pend_r);
    ram_waddr = cmd.clear_step ? clr_idx_r : wr_idx_r;
    ram_wdata = cmd.clear_step ? '0 : mark_wdata;
  end

  // next-state logic
  always_comb begin
    req_nxt      = req_r;
    base_nxt     = base_r;
    diff_nxt     = diff_r;
    rd_idx_nxt   = rd_idx_r;
    eval_idx_nxt = eval_idx_r;
    eval_v_nxt   = eval_v_r;
    run_nxt      = run_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    mrd_idx_nxt  = mrd_idx_r;
    wr_idx_nxt   = wr_idx_r;
    pend_nxt     = pend_r;
    clr_idx_nxt  = clr_idx_r;
    res_nxt      = res_r;

    if (cfg_we) begin
      base_nxt = cfg_wdata;
    end
    if (cmd.load) begin
      req_nxt = in_req;
    end
    // offset of the free address inside the pool, borrow on top
    if (cmd.check) begin
      diff_nxt = {1'b0, req_r.free_address} - {1'b0, base_r};
    end
    if (cmd.clear_step) begin
      clr_idx_nxt = clr_idx_r + AW'(1);
    end
    if (cmd.scan_init) begin
      rd_idx_nxt = '0;
      eval_v_nxt = 1'b0;
      run_nxt    = '0;
    end
    // stream words: read one ahead, evaluate the one returned
    if (cmd.scan_step) begin
      rd_idx_nxt   = rd_idx_r + AW'(1);
      eval_idx_nxt = rd_idx_r;
      eval_v_nxt   = 1'b1;
      if (eval_v_r) begin
        run_nxt = total[W-1][CNT_W-1:0];
      end
    end
    if (cmd.load_range) begin
      lo_nxt      = is_alloc ? lo_alloc : lo_free;
      hi_nxt      = is_alloc ? end_off : hi_free;
      mrd_idx_nxt = is_alloc ? lo_alloc[OFF_W-1:WB] : lo_free[OFF_W-1:WB];
      pend_nxt    = 1'b0;
    end
    if (cmd.mark_step) begin
      mrd_idx_nxt = mrd_idx_r + AW'(1);
      wr_idx_nxt  = mrd_idx_r;
      pend_nxt    = 1'b1;
    end
    // result register
    if (cmd.res_err) begin
      res_nxt.result_address = '0;
      res_nxt.status         = (zero_cnt || !is_alloc) ? ST_BAD : ST_NOFIT;
    end
    if (cmd.res_nofit) begin
      res_nxt.result_address = '0;
      res_nxt.status         = ST_NOFIT;
    end
    if (cmd.res_ok) begin
      res_nxt.result_address = is_alloc ? (base_r + 32'(lo_r)) : '0;
      res_nxt.status         = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= '0;
      clr_idx_r <= '0;
      eval_v_r  <= 1'b0;
      pend_r    <= 1'b0;
    end else begin
      base_r    <= base_nxt;
      clr_idx_r <= clr_idx_nxt;
      eval_v_r  <= eval_v_nxt;
      pend_r    <= pend_nxt;
    end
    req_r      <= req_nxt;
    diff_r     <= diff_nxt;
    rd_idx_r   <= rd_idx_nxt;
    eval_idx_r <= eval_idx_nxt;
    run_r      <= run_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mrd_idx_r  <= mrd_idx_nxt;
    wr_idx_r   <= wr_idx_nxt;
    res_r      <= res_nxt;
  end

  // status to controller
  always_comb begin
    sts.err        = zero_cnt || (is_alloc ? too_big : free_bad);
    sts.alloc      = is_alloc;
    sts.hit        = any_hit;
    sts.scan_end   = eval_v_r && (eval_idx_r == LAST_IDX) && (hit_vec == '0);
    sts.mark_last  = pend_r && (wr_idx_r == hi_word);
    sts.clear_last = (clr_idx_r == LAST_IDX);
  end

  assign out_rsp = res_r;

endmodule

`default_nettype wire

// File: hw/rtl/first_fit_bitmap_allocator_top.sv
// channel   ports                          transfer
// config    cfg_we, cfg_wdata              pool base written when cfg_we is high
// request   start, busy, in_req            taken when start is high and busy is low
// result    out_valid, out_rsp             one cycle per request, cannot be held off
//
// the allocation map sits in a RAM of 16-bit words, one bit per pool byte
// allocate: the check and evaluation states, a scan that reads one map word per cycle,
// a read-modify-write pass over the words to be marked, and a result state; the
// single RAM read port is shared by the scan and the mark pass and sets their pace
// free: the check and evaluation states, a pass over the words covered, a result state
// after reset a clearing pass over every map word holds busy high
// a bad request is answered after the check and evaluation states
`timescale 1ns / 1ps
`default_nettype none

module first_fit_bitmap_allocator_top #(
  parameter int POOL_BYTES = ffba_pkg::POOL_BYTES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic [31:0]    cfg_wdata,
  input  wire logic           start,
  output logic                busy,
  input  wire ffba_pkg::req_t in_req,
  output logic                out_valid,
  output ffba_pkg::rsp_t      out_rsp
);

  import ffba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  // map, scan and result datapath
  ffba_dp #(
    .POOL_BYTES (POOL_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_req),
    .cmd       (cmd),
    .sts       (sts),
    .out_rsp   (out_rsp)
  );

  // a taken request keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after request");

  // each result strobe lasts one cycle
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // status is a defined code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.status == ST_OK || out_rsp.status == ST_NOFIT ||
                   out_rsp.status == ST_BAD))
    else $error("undefined status code");

  // failed requests return address zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.status != ST_OK) |-> (out_rsp.result_address == 32'd0))
    else $error("nonzero address on failed request");

  // a result comes only while a request is in flight
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result outside a request");

endmodule

`default_nettype wire

// File: tb/first_fit_bitmap_allocator_top_tb.sv
`timescale 1ns / 1ps

module first_fit_bitmap_allocator_top_tb;
  import ffba_pkg::*;

  localparam int POOL      = POOL_BYTES_DEF;
  localparam int MAX_GAP   = 60;
  localparam int TAIL      = 200;
  localparam int LIMIT     = 1500000;
  localparam int PHASE_LEN = 220;
  localparam int N_PHASES  = 7;

  // kinds of entries in the stimulus plan
  typedef enum logic [1:0] {
    STEP_REQ,
    STEP_CFG,
    STEP_DRAIN
  } plan_kind_t;

  typedef struct packed {
    plan_kind_t  kind;
    req_t        req;
    logic [31:0] base;
  } plan_step_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        start     = 1'b0;
  req_t        in_req    = '0;
  logic        busy;
  logic        out_valid;
  rsp_t        out_rsp;

  // stimulus plan and outstanding grants
  plan_step_t  request_plan[$];
  rsp_t        grant_q[$];

  // shadow of the allocator state
  logic        byte_used[POOL];
  logic [31:0] base_shadow;

  int unsigned accept_cnt = 0;
  int unsigned raise_cnt  = 0;
  int unsigned cfg_writes = 0;
  int unsigned mismatches = 0;
  int unsigned n_ok       = 0;
  int unsigned n_nofit    = 0;
  int unsigned n_bad      = 0;
  int unsigned cycles     = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  first_fit_bitmap_allocator_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  always #5 clk = ~clk;

  // mismatch note
  task automatic flag_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // first-fit allocate or range free against the shadow map
  function automatic rsp_t compute_grant(input req_t r);
    rsp_t            g;
    int unsigned     run;
    int              first;
    int              i;
    longint unsigned offs;
    g.result_address = '0;
    g.status         = ST_OK;
    if (r.byte_count == '0) begin
      g.status = ST_BAD;
    end else if (r.func == FUNC_ALLOC) begin
      g.status = ST_NOFIT;
      if (r.byte_count <= POOL) begin
        run   = 0;
        first = -1;
        for (i = 0; i < POOL && first < 0; i++) begin
          if (byte_used[i]) begin
            run = 0;
          end else begin
            run++;
            if (run == r.byte_count) first = i + 1 - int'(r.byte_count);
          end
        end
        if (first >= 0) begin
          for (i = first; i < first + int'(r.byte_count); i++) byte_used[i] = 1'b1;
          g.result_address = base_shadow + 32'(first);
          g.status         = ST_OK;
        end
      end
    end else begin
      if (r.free_address < base_shadow) begin
        g.status = ST_BAD;
      end else begin
        offs = longint'(r.free_address) - longint'(base_shadow);
        if (offs + r.byte_count > POOL) begin
          g.status = ST_BAD;
        end else begin
          for (i = int'(offs); i < int'(offs) + int'(r.byte_count); i++) begin
            byte_used[i] = 1'b0;
          end
        end
      end
    end
    return g;
  endfunction

  function automatic void add_request(input logic f, input int unsigned cnt,
                                      input logic [31:0] addr);
    plan_step_t s;
    s.kind             = STEP_REQ;
    s.req.func         = f;
    s.req.byte_count   = CNT_W'(cnt);
    s.req.free_address = addr;
    s.base             = '0;
    request_plan.push_back(s);
  endfunction

  function automatic void add_marker(input plan_kind_t k, input logic [31:0] b);
    plan_step_t s;
    s.kind = k;
    s.req  = '0;
    s.base = b;
    request_plan.push_back(s);
  endfunction

  // driver: request and config port, changed on the falling edge
  always @(negedge clk) begin : driver
    logic        nx_start;
    req_t        nx_req;
    logic        nx_we;
    logic [31:0] nx_wd;
    nx_start = start;
    nx_req   = in_req;
    nx_we    = 1'b0;
    nx_wd    = cfg_wdata;
    if (rst_n) begin
      // current request taken at the last edge
      if (nx_start && accept_cnt == raise_cnt) begin
        nx_start = 1'b0;
        burst_left--;
        if (burst_left == 0) begin
          if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(20, 60);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 8);
            gap_left   = $urandom_range(0, MAX_GAP);
          end
        end
      end
      // next plan entry
      if (!nx_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_plan.size() > 0) begin
          case (request_plan[0].kind)
            STEP_REQ: begin
              nx_req   = request_plan[0].req;
              nx_start = 1'b1;
              raise_cnt++;
              void'(request_plan.pop_front());
            end
            STEP_CFG: begin
              if (grant_q.size() == 0 && !busy && !cfg_we) begin
                nx_we = 1'b1;
                nx_wd = request_plan[0].base;
                void'(request_plan.pop_front());
              end
            end
            default: begin
              if (grant_q.size() == 0 && !busy) void'(request_plan.pop_front());
            end
          endcase
        end
      end
    end
    start     <= nx_start;
    in_req    <= nx_req;
    cfg_we    <= nx_we;
    cfg_wdata <= nx_wd;
  end

  // monitor: config, request acceptance and result check on the rising edge
  always @(posedge clk) begin : monitor
    rsp_t want;
    int   k;
    if (!rst_n) begin
      base_shadow = '0;
      for (k = 0; k < POOL; k++) byte_used[k] = 1'b0;
    end else begin
      if (cfg_we) begin
        base_shadow = cfg_wdata;
        cfg_writes++;
      end
      if (out_valid) begin
        if (grant_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result addr=%h status=%0d",
                                  out_rsp.result_address, out_rsp.status));
        end else begin
          want = grant_q.pop_front();
          if (out_rsp.result_address !== want.result_address) begin
            flag_mismatch($sformatf("result_address got %h want %h",
                                    out_rsp.result_address, want.result_address));
          end
          if (out_rsp.status !== want.status) begin
            flag_mismatch($sformatf("status got %0d want %0d",
                                    out_rsp.status, want.status));
          end
          case (want.status)
            ST_OK:    n_ok++;
            ST_NOFIT: n_nofit++;
            default:  n_bad++;
          endcase
        end
      end
      if (start && !busy) begin
        grant_q.push_back(compute_grant(in_req));
        accept_cnt++;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [31:0] bases[N_PHASES];
    logic [31:0] b;
    int          sel;
    int          offs;
    int          cnt;
    int          p;
    int          n;

    // directed: zero counts, oversize, full pool, first fit, range checks
    add_marker(STEP_CFG, 32'h0000_0000);
    add_request(FUNC_ALLOC, 0, 32'hFFFF_FFFF);
    add_request(FUNC_FREE, 0, 32'd5);
    add_request(FUNC_ALLOC, 1025, 32'h0);
    add_request(FUNC_ALLOC, 2047, 32'h0);
    add_request(FUNC_ALLOC, 1024, 32'h0);
    add_request(FUNC_ALLOC, 1, 32'h0);
    add_request(FUNC_FREE, 1024, 32'd0);
    add_request(FUNC_ALLOC, 1, 32'h0);
    add_request(FUNC_ALLOC, 3, 32'h0);
    add_request(FUNC_ALLOC, 1, 32'h0);
    add_request(FUNC_FREE, 3, 32'd1);
    add_request(FUNC_ALLOC, 2, 32'h0);
    add_request(FUNC_FREE, 10, 32'd600);
    add_request(FUNC_FREE, 5, 32'd1020);
    add_request(FUNC_FREE, 1, 32'd1023);
    add_request(FUNC_FREE, 1, 32'd1024);
    // pool straddling the top of the address space
    add_marker(STEP_CFG, 32'hFFFF_FF00);
    add_request(FUNC_FREE, 1, 32'h0000_0000);
    add_request(FUNC_FREE, 1024, 32'hFFFF_FF00);
    add_request(FUNC_ALLOC, 512, 32'h0);
    add_request(FUNC_ALLOC, 512, 32'h0);
    add_request(FUNC_FREE, 2, 32'hFFFF_FFFF);
    add_marker(STEP_CFG, 32'hFFFF_FFFF);
    add_request(FUNC_FREE, 1024, 32'hFFFF_FFFF);
    add_request(FUNC_ALLOC, 1, 32'h0);
    add_request(FUNC_ALLOC, 1, 32'h0);
    add_request(FUNC_FREE, 1, 32'hFFFF_FFFE);

    // random phases, one pool base each
    bases[0] = 32'h0000_0000;
    bases[1] = $urandom();
    bases[2] = 32'hFFFF_FFFF;
    bases[3] = 32'h8000_0000;
    bases[4] = 32'hFFFF_FC00;
    bases[5] = $urandom();
    bases[6] = 32'h0000_0400;
    for (p = 0; p < N_PHASES; p++) begin
      b = bases[p];
      add_marker(STEP_CFG, b);
      for (n = 0; n < PHASE_LEN; n++) begin
        if (n == PHASE_LEN / 2) add_marker(STEP_DRAIN, '0);
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
          // allocate, mostly small
          cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(1, POOL) : $urandom_range(1, 40);
          add_request(FUNC_ALLOC, cnt, $urandom());
        end else if (sel < 90) begin
          // free inside the pool
          if ($urandom_range(0, 49) == 0) begin
            offs = 0;
            cnt  = POOL;
          end else begin
            offs = $urandom_range(0, POOL - 1);
            cnt  = (POOL - offs < 64) ? POOL - offs : 64;
            cnt  = ($urandom_range(0, 9) == 0) ? cnt : $urandom_range(1, cnt);
          end
          add_request(FUNC_FREE, cnt, b + 32'(offs));
        end else begin
          // malformed requests
          case ($urandom_range(0, 4))
            0: add_request(1'($urandom_range(0, 1)), 0, $urandom());
            1: add_request(FUNC_ALLOC, $urandom_range(POOL + 1, 2047), $urandom());
            2: add_request(FUNC_FREE, $urandom_range(1, 2047), $urandom());
            3: begin
              offs = $urandom_range(0, POOL - 1);
              add_request(FUNC_FREE, POOL - offs + $urandom_range(1, 64), b + 32'(offs));
            end
            default: add_request(FUNC_FREE, $urandom_range(1, 64), b - $urandom_range(1, 16));
          endcase
        end
      end
    end

    // reset, released on a falling edge
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // wait for all requests and their results
    while (request_plan.size() != 0 || start) @(posedge clk);
    while (grant_q.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (grant_q.size() != 0) flag_mismatch($sformatf("%0d results missing", grant_q.size()));

    $display("%0d requests across %0d pool base settings, %0d mismatches",
             accept_cnt, cfg_writes, mismatches);
    $display("granted %0d, no fit %0d, rejected %0d", n_ok, n_nofit, n_bad);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: first_fit_bitmap_allocator_top.f
hw/rtl/ffba_pkg.sv
hw/rtl/ffba_ram.sv
hw/rtl/ffba_ctrl.sv
hw/rtl/ffba_dp.sv
hw/rtl/first_fit_bitmap_allocator_top.sv
tb/first_fit_bitmap_allocator_top_tb.sv
